>>> rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, table depths and codes of the best-fit pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bfa_pkg;
    localparam int FREE_ENTRIES = 64;
    localparam int USED_ENTRIES = 64;
    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int UW = $clog2(USED_ENTRIES);
    localparam logic [30:0] POOL_BYTES = 31'd1073741824;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] req_size;
        logic [29:0] req_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [29:0] grant_offset;
        logic [30:0] grant_size;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, clear scan results
        logic clr_idx;    // restart scan index
        logic scan_used;  // examine used entry at index
        logic scan_free;  // examine free entry at index
        logic inc_idx;    // advance index
        logic commit;     // apply table update and build result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       idx_last;
    } sts_t;
endpackage
`default_nettype wire

>>> rtl/core/bfa_if.sv
// ----------------------------------------------------------------------------
// bfa_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface bfa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: accept, scan used table, scan free table (not for a query), drain, commit, deliver.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bfa_pkg::cmd_t    cmd,
    input  wire bfa_pkg::sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_USED = 3'd1;
    localparam logic [2:0] S_FREE = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequence the scans; result register holds until taken
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next = S_USED;
                end
            end
            S_USED:
            begin
                cmd.scan_used = 1'b1;
                cmd.inc_idx = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next = (sts.op == bfa_pkg::OP_QUERY) ? S_DRAIN : S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.scan_free = 1'b1;
                cmd.inc_idx = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // wait for the last registered table read to be examined
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp
// Tables, scan registers, best-fit compare and commit update.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bfa_pkg::req_t req,
    input  wire bfa_pkg::cmd_t cmd,
    output bfa_pkg::sts_t      sts,
    output bfa_pkg::rsp_t      rsp
);
    localparam int FN = bfa_pkg::FREE_ENTRIES;
    localparam int UN = bfa_pkg::USED_ENTRIES;
    localparam int FW = bfa_pkg::FW;
    localparam int UW = bfa_pkg::UW;
    localparam int IW = (FW > UW) ? FW : UW;

    // table payloads live in memories read one entry a cycle through registers
    logic [29:0] fstart_mem [FN];
    logic [30:0] flen_mem   [FN];
    logic [FN-1:0] flive_reg;
    logic [29:0] ustart_mem [UN];
    logic [30:0] ulen_mem   [UN];
    logic [UN-1:0] ulive_reg;

    // entry 0 holds the whole pool until its first write
    logic          f0_fresh_reg;

    bfa_pkg::req_t req_reg;
    bfa_pkg::rsp_t rsp_reg;
    bfa_pkg::rsp_t rsp_next;
    logic [IW-1:0] idx_reg;

    // registered table reads and the index they belong to
    logic [29:0]   fstart_rd_reg;
    logic [30:0]   flen_rd_reg;
    logic          rd_fresh_reg;
    logic [29:0]   ustart_rd_reg;
    logic [30:0]   ulen_rd_reg;
    logic          uvld_reg, fvld_reg;
    logic [FW-1:0] fi_d_reg;
    logic [UW-1:0] ui_d_reg;

    // scan results
    logic          gfound_reg;
    logic [UW-1:0] gidx_reg;
    logic [30:0]   glen_reg;
    logic          efound_reg;   // empty used slot
    logic [UW-1:0] eidx_reg;
    logic          bfound_reg;
    logic [FW-1:0] bidx_reg;
    logic [29:0]   bstart_reg;
    logic [30:0]   blen_reg;
    logic          lfound_reg, hfound_reg, ffound_reg;
    logic [FW-1:0] lidx_reg, hidx_reg, fidx_reg;
    logic [29:0]   lstart_reg;
    logic [30:0]   llen_reg, hlen_reg;

    logic [FW-1:0] fi;
    logic [UW-1:0] ui;
    logic [29:0]   cur_start;
    logic [30:0]   cur_len;
    logic [30:0]   cur_end;
    logic [30:0]   gr_end;
    logic          fits, better;

    // commit controls
    logic          do_alloc, do_free;
    logic          fwr_en;
    logic [FW-1:0] fwr_idx;
    logic [29:0]   fwr_start;
    logic [30:0]   fwr_len;

    assign fi = idx_reg[FW-1:0];
    assign ui = idx_reg[UW-1:0];
    assign cur_start = rd_fresh_reg ? 30'd0 : fstart_rd_reg;
    assign cur_len   = rd_fresh_reg ? bfa_pkg::POOL_BYTES : flen_rd_reg;
    assign cur_end   = {1'b0, cur_start} + cur_len;
    assign gr_end    = {1'b0, req_reg.req_offset} + glen_reg;
    assign fits   = flive_reg[fi_d_reg] && (cur_len >= req_reg.req_size);
    assign better = !bfound_reg || (cur_len < blen_reg) ||
                    ((cur_len == blen_reg) && (cur_start < bstart_reg));

    assign sts.op = req_reg.op;
    assign sts.idx_last = (req_reg.op == bfa_pkg::OP_QUERY || req_reg.op == bfa_pkg::OP_FREE
                          || req_reg.op == bfa_pkg::OP_ALLOC) ?
                          ((cmd.scan_free) ? (fi == FW'(FN - 1)) : (ui == UW'(UN - 1)))
                          : 1'b1;
    assign rsp = rsp_reg;

    // request capture and scan index
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            uvld_reg <= 1'b0;
            fvld_reg <= 1'b0;
            fi_d_reg <= '0;
            ui_d_reg <= '0;
        end
        else
        begin
            uvld_reg <= cmd.scan_used;
            fvld_reg <= cmd.scan_free;
            fi_d_reg <= fi;
            ui_d_reg <= ui;
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // scan registers, fed by the registered table read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gfound_reg <= 1'b0;
            efound_reg <= 1'b0;
            bfound_reg <= 1'b0;
            lfound_reg <= 1'b0;
            hfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end
        if (uvld_reg)
        begin
            if (ulive_reg[ui_d_reg] && !gfound_reg && ustart_rd_reg == req_reg.req_offset)
            begin
                gfound_reg <= 1'b1;
                gidx_reg <= ui_d_reg;
                glen_reg <= ulen_rd_reg;
            end
            if (!ulive_reg[ui_d_reg] && !efound_reg)
            begin
                efound_reg <= 1'b1;
                eidx_reg <= ui_d_reg;
            end
        end
        if (fvld_reg)
        begin
            if (fits && better)
            begin
                bfound_reg <= 1'b1;
                bidx_reg <= fi_d_reg;
                bstart_reg <= cur_start;
                blen_reg <= cur_len;
            end
            if (!flive_reg[fi_d_reg])
            begin
                if (!ffound_reg)
                begin
                    ffound_reg <= 1'b1;
                    fidx_reg <= fi_d_reg;
                end
            end
            else if (!lfound_reg && cur_end == {1'b0, req_reg.req_offset})
            begin
                lfound_reg <= 1'b1;
                lidx_reg <= fi_d_reg;
                lstart_reg <= cur_start;
                llen_reg <= cur_len;
            end
            else if (!hfound_reg && {1'b0, cur_start} == gr_end)
            begin
                hfound_reg <= 1'b1;
                hidx_reg <= fi_d_reg;
                hlen_reg <= cur_len;
            end
        end
    end

    // commit: decide outcome, free table write and result
    always_comb
    begin
        do_alloc = 1'b0;
        do_free = 1'b0;
        fwr_en = 1'b0;
        fwr_idx = '0;
        fwr_start = '0;
        fwr_len = '0;
        rsp_next = '{bfa_pkg::ST_NOTALLOC, 30'd0, 31'd0};
        case (req_reg.op)
            bfa_pkg::OP_ALLOC:
            begin
                if (req_reg.req_size == '0)
                    rsp_next.status = bfa_pkg::ST_ZERO;
                else if (!bfound_reg)
                    rsp_next.status = bfa_pkg::ST_NOFIT;
                else if (!efound_reg)
                    rsp_next.status = bfa_pkg::ST_FULL;
                else
                begin
                    do_alloc = 1'b1;
                    rsp_next = '{bfa_pkg::ST_OK, bstart_reg, req_reg.req_size};
                end
            end
            bfa_pkg::OP_FREE:
            begin
                if (gfound_reg)
                begin
                    if (lfound_reg || hfound_reg || ffound_reg)
                    begin
                        do_free = 1'b1;
                        rsp_next.status = bfa_pkg::ST_OK;
                    end
                    else
                    begin
                        rsp_next.status = bfa_pkg::ST_FULL;
                    end
                end
            end
            bfa_pkg::OP_QUERY:
            begin
                if (gfound_reg)
                    rsp_next = '{bfa_pkg::ST_OK, 30'd0, glen_reg};
            end
            default:
            begin
                rsp_next.status = bfa_pkg::ST_NOTALLOC;
            end
        endcase
        // trim the chosen block from the bottom
        if (do_alloc && (blen_reg > req_reg.req_size))
        begin
            fwr_en = 1'b1;
            fwr_idx = bidx_reg;
            fwr_start = bstart_reg + req_reg.req_size[29:0];
            fwr_len = blen_reg - req_reg.req_size;
        end
        // merge into lower neighbor, else higher neighbor, else an empty slot
        if (do_free)
        begin
            fwr_en = 1'b1;
            if (lfound_reg)
            begin
                fwr_idx = lidx_reg;
                fwr_start = lstart_reg;
                fwr_len = llen_reg + glen_reg + (hfound_reg ? hlen_reg : 31'd0);
            end
            else if (hfound_reg)
            begin
                fwr_idx = hidx_reg;
                fwr_start = req_reg.req_offset;
                fwr_len = hlen_reg + glen_reg;
            end
            else
            begin
                fwr_idx = fidx_reg;
                fwr_start = req_reg.req_offset;
                fwr_len = glen_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // free table payload: registered read at scan index, one write at commit
    always_ff @(posedge clk)
    begin
        fstart_rd_reg <= fstart_mem[fi];
        flen_rd_reg <= flen_mem[fi];
        rd_fresh_reg <= f0_fresh_reg && (fi == '0);
        if (cmd.commit && fwr_en)
        begin
            fstart_mem[fwr_idx] <= fwr_start;
            flen_mem[fwr_idx] <= fwr_len;
        end
    end

    // used table payload (no reset)
    always_ff @(posedge clk)
    begin
        ustart_rd_reg <= ustart_mem[ui];
        ulen_rd_reg <= ulen_mem[ui];
        if (cmd.commit && do_alloc)
        begin
            ustart_mem[eidx_reg] <= bstart_reg;
            ulen_mem[eidx_reg] <= req_reg.req_size;
        end
    end

    // live bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ulive_reg <= '0;
            flive_reg <= FN'(1);
            f0_fresh_reg <= 1'b1;
        end
        else if (cmd.commit)
        begin
            if (do_alloc)
            begin
                ulive_reg[eidx_reg] <= 1'b1;
                if (!(blen_reg > req_reg.req_size))
                begin
                    flive_reg[bidx_reg] <= 1'b0;
                end
            end
            if (do_free)
            begin
                ulive_reg[gidx_reg] <= 1'b0;
                if (lfound_reg && hfound_reg)
                begin
                    flive_reg[hidx_reg] <= 1'b0;
                end
                else if (!lfound_reg && !hfound_reg)
                begin
                    flive_reg[fidx_reg] <= 1'b1;
                end
            end
            if (fwr_en && (fwr_idx == '0))
            begin
                f0_fresh_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/best_fit_allocator_coalescing.sv
// ----------------------------------------------------------------------------
// best_fit_allocator_coalescing
// Best-fit byte pool allocator with free-block coalescing.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload
// req       in    op, req_size, req_offset
// rsp       out   status, grant_offset, grant_size
//
// A request is accepted, then the used table and then the free table are
// scanned entry by entry, the last registered table read is examined, and
// the result is committed and delivered; a query skips the free scan. One
// request is in flight at a time. The result holds on rsp until taken.
// Reset restores the whole pool as one free block and empties the grant
// table.
`default_nettype none
module best_fit_allocator_coalescing (
    input  wire logic clk,
    input  wire logic rst_n,
    bfa_if.sink       req,
    bfa_if.source     rsp
);
    bfa_pkg::cmd_t cmd;
    bfa_pkg::sts_t sts;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bfa_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp.data)
    );
endmodule
`default_nettype wire
